// ===== rtl/core/arp_responder_cache_core_defines.svh =====
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Property wrappers for the ARP responder cache datapath.
// ----------------------------------------------------------------------------
`ifndef ARP_RESPONDER_CACHE_CORE_DEFINES_SVH
`define ARP_RESPONDER_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ARC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ARC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Table sizing, register indexes, opcodes, action codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package arc_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int CFG_W = 48;

    // Configuration register indexes
    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    // Received ARP opcodes
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

    // Opcodes of frames to send
    localparam logic [1:0] OUT_OP_NONE    = 2'd0;
    localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
    localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

    // Item kinds
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_REPLY  = 2'd1,
        ACT_BCAST  = 2'd2,
        ACT_HIT    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic load;     // capture the request and restart the scan
        logic scan;     // compare one table entry
        logic finish;   // form the result and update the table
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;    // every valid entry has been compared
        logic match;        // the current entry holds the search key
        logic out_free;     // result register can take a new result
    } ctrl_status_t;

endpackage

// ===== rtl/core/arp_responder_cache_core.sv =====
// Flow: a request is captured, then the table is scanned until a match or the end
// of the stored pairs (up to 16), one compare a cycle, then the result is written.
// No new request is taken until the last one is in the result register, since the
// table is scanned entry by entry; a held result keeps the next in its decide step.
// Reset: asynchronous, active low; clears the pair count, configuration and
// control state. No clearing pass: stored pairs past the count are never read.
// ----------------------------------------------------------------------------
// ARP responder cache core
// Answers ARP requests, learns sender pairs and serves MAC lookups from a
// sixteen-entry IPv4-to-MAC table.
// ----------------------------------------------------------------------------
module arp_responder_cache_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] opcode,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [31:0] target_ip,
    input  logic [31:0] query_ip,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [1:0]  out_opcode,
    output logic [47:0] dest_mac,
    output logic [31:0] dest_ip,
    output logic [31:0] source_ip,
    output logic [47:0] found_mac,
    output logic        learned,
    output logic        table_full
);
    import arc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    arc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    arc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .opcode     (opcode),
        .sender_mac (sender_mac),
        .sender_ip  (sender_ip),
        .target_ip  (target_ip),
        .query_ip   (query_ip),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .out_opcode (out_opcode),
        .dest_mac   (dest_mac),
        .dest_ip    (dest_ip),
        .source_ip  (source_ip),
        .found_mac  (found_mac),
        .learned    (learned),
        .table_full (table_full)
    );

endmodule

// ===== rtl/core/arc_datapath.sv =====
// ----------------------------------------------------------------------------
// ARP cache datapath
// Request registers, pair table, scan counter, result register and the
// configuration registers.
// ----------------------------------------------------------------------------
`include "arp_responder_cache_core_defines.svh"

module arc_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [47:0]                cfg_data,
    input  logic                       kind,
    input  logic [15:0]                opcode,
    input  logic [47:0]                sender_mac,
    input  logic [31:0]                sender_ip,
    input  logic [31:0]                target_ip,
    input  logic [31:0]                query_ip,
    input  arc_pkg::ctrl_cmd_t         cmd,
    output arc_pkg::ctrl_status_t      status,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 action,
    output logic [1:0]                 out_opcode,
    output logic [47:0]                dest_mac,
    output logic [31:0]                dest_ip,
    output logic [31:0]                source_ip,
    output logic [47:0]                found_mac,
    output logic                       learned,
    output logic                       table_full
);
    import arc_pkg::*;

    // Configuration
    logic [MAC_W-1:0] own_mac_reg;
    logic [IP_W-1:0]  own_ip_reg;

    // Captured request
    logic             kind_reg;
    logic             op_req_reg;
    logic             op_rep_reg;
    logic [MAC_W-1:0] smac_reg;
    logic [IP_W-1:0]  sip_reg;
    logic [IP_W-1:0]  tip_reg;
    logic [IP_W-1:0]  qip_reg;
    logic [IP_W-1:0]  key_reg;

    // Table and scan
    logic [IP_W-1:0]  entry_ip_reg  [TABLE_DEPTH];
    logic [MAC_W-1:0] entry_mac_reg [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             hit_reg;
    logic [MAC_W-1:0] hit_mac_reg;

    // Result register
    logic             out_valid_reg;
    action_t          action_reg;
    logic [1:0]       out_opcode_reg;
    logic [MAC_W-1:0] dest_mac_reg;
    logic [IP_W-1:0]  dest_ip_reg;
    logic [IP_W-1:0]  source_ip_reg;
    logic [MAC_W-1:0] found_mac_reg;
    logic             learned_reg;
    logic             table_full_reg;

    // Result next values
    action_t          action_next;
    logic [1:0]       out_opcode_next;
    logic [MAC_W-1:0] dest_mac_next;
    logic [IP_W-1:0]  dest_ip_next;
    logic [IP_W-1:0]  source_ip_next;
    logic [MAC_W-1:0] found_mac_next;
    logic             learned_next;
    logic             table_full_next;
    logic             learn_op;
    logic             tbl_full;

    // Status to the controller
    always_comb
    begin
        status.scan_done = (scan_idx_reg == count_reg);
        status.match     = (scan_idx_reg != count_reg) &&
                           (entry_ip_reg[scan_idx_reg[IDX_W-1:0]] == key_reg);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_MAC: own_mac_reg <= cfg_data;
                CFG_OWN_IP:  own_ip_reg  <= cfg_data[IP_W-1:0];
                default:     own_mac_reg <= own_mac_reg;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            op_req_reg <= (opcode == ARP_OP_REQUEST);
            op_rep_reg <= (opcode == ARP_OP_REPLY);
            smac_reg   <= sender_mac;
            sip_reg    <= sender_ip;
            tip_reg    <= target_ip;
            qip_reg    <= query_ip;
            key_reg    <= (kind == KIND_LOOKUP) ? query_ip : sender_ip;
        end
    end

    // Step the scan one entry a cycle, hold on a match
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (status.match)
                hit_reg <= 1'b1;
            else if (!status.scan_done)
                scan_idx_reg <= scan_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && status.match)
            hit_mac_reg <= entry_mac_reg[scan_idx_reg[IDX_W-1:0]];
    end

    // Form the result
    always_comb
    begin
        learn_op        = (kind_reg == KIND_PACKET) && (op_req_reg || op_rep_reg);
        tbl_full        = (count_reg == CNT_W'(TABLE_DEPTH));
        action_next     = ACT_NONE;
        out_opcode_next = OUT_OP_NONE;
        dest_mac_next   = '0;
        dest_ip_next    = '0;
        source_ip_next  = '0;
        found_mac_next  = '0;
        learned_next    = learn_op && !hit_reg && !tbl_full;
        table_full_next = learn_op && !hit_reg && tbl_full;
        if (kind_reg == KIND_PACKET)
        begin
            if (op_req_reg)
            begin
                action_next     = ACT_REPLY;
                out_opcode_next = OUT_OP_REPLY;
                dest_mac_next   = smac_reg;
                dest_ip_next    = sip_reg;
                source_ip_next  = tip_reg;
            end
        end
        else if (hit_reg)
        begin
            action_next    = ACT_HIT;
            found_mac_next = hit_mac_reg;
        end
        else
        begin
            action_next     = ACT_BCAST;
            out_opcode_next = OUT_OP_REQUEST;
            dest_ip_next    = qip_reg;
            source_ip_next  = own_ip_reg;
        end
    end

    // Store a new pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.finish && learned_next)
            count_reg <= count_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && learned_next)
        begin
            entry_ip_reg[count_reg[IDX_W-1:0]]  <= sip_reg;
            entry_mac_reg[count_reg[IDX_W-1:0]] <= smac_reg;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            action_reg     <= action_next;
            out_opcode_reg <= out_opcode_next;
            dest_mac_reg   <= dest_mac_next;
            dest_ip_reg    <= dest_ip_next;
            source_ip_reg  <= source_ip_next;
            found_mac_reg  <= found_mac_next;
            learned_reg    <= learned_next;
            table_full_reg <= table_full_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign out_opcode = out_opcode_reg;
    assign dest_mac   = dest_mac_reg;
    assign dest_ip    = dest_ip_reg;
    assign source_ip  = source_ip_reg;
    assign found_mac  = found_mac_reg;
    assign learned    = learned_reg;
    assign table_full = table_full_reg;

    // Checks
    `ARC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH), "entry count overflow")
    `ARC_ASSERT_IMP(a_scan_bound, 1'b1, scan_idx_reg <= count_reg, "scan index past entry count")
    `ARC_ASSERT_IMP(a_finish_free, cmd.finish, status.out_free, "result overwritten before taken")
    `ARC_ASSERT_NEXT(a_learn_count, cmd.finish && learned_next, count_reg == $past(count_reg) + 1'b1, "learned pair not counted")

endmodule

// ===== rtl/core/arc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences capture, table scan and result write for one request at a time.
// ----------------------------------------------------------------------------
module arc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  arc_pkg::ctrl_status_t  status,
    output arc_pkg::ctrl_cmd_t     cmd
);
    import arc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (status.match || status.scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// ARP responder cache testbench
// Drives received ARP packets and lookup queries into the core under random
// flow control. Every accepted request is run through a local table model.
// Each delivered result is compared with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import arc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int POOL_SIZE   = 24;
    localparam int REPORT_MAX  = 10;

    // Whether a directed row carries its own expectation
    localparam logic TYPED    = 1'b1;
    localparam logic MODELLED = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [15:0] opcode;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [31:0] tip;
        logic [31:0] qip;
    } arp_item_t;

    typedef struct packed {
        action_t     action;
        logic [1:0]  out_opcode;
        logic [47:0] dest_mac;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [47:0] found_mac;
        logic        learned;
        logic        table_full;
    } arp_result_t;

    typedef struct packed {
        arp_item_t   stim;
        logic        pinned;
        arp_result_t want;
    } arp_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_OWN_MAC;
    logic [47:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = KIND_PACKET;
    logic [15:0] opcode = '0;
    logic [47:0] sender_mac = '0;
    logic [31:0] sender_ip = '0;
    logic [31:0] target_ip = '0;
    logic [31:0] query_ip = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  action;
    logic [1:0]  out_opcode;
    logic [47:0] dest_mac;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [47:0] found_mac;
    logic        learned;
    logic        table_full;

    // Expectation riding along with a directed request
    logic        pin_on = 1'b0;
    arp_result_t pin_want = '0;

    // Local copy of the pair table and station registers
    logic [31:0] known_ip [TABLE_DEPTH];
    logic [47:0] known_mac [TABLE_DEPTH];
    int          known_count = 0;
    logic [47:0] station_mac = '0;
    logic [31:0] station_ip = '0;

    arp_result_t pending_outcomes [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          sender_idle_pct = 15;
    int          rx_idle_pct = 55;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic [31:0] ip_pool [POOL_SIZE];

    arp_row_t directed_rows [0:20] = '{
        // lookup on an empty table: broadcast request from our own address
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h0}, TYPED,
          '{ACT_BCAST, OUT_OP_REQUEST, 48'h0, 32'h0, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0}},
        // unknown opcodes are ignored
        '{'{KIND_PACKET, 16'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF}, TYPED, '0},
        '{'{KIND_PACKET, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF}, TYPED, '0},
        '{'{KIND_PACKET, 16'h0101, 48'h1, 32'h2, 32'h0, 32'h0}, MODELLED, '0},
        // request from a new sender: reply and learn
        '{'{KIND_PACKET, ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
          TYPED, '{ACT_REPLY, OUT_OP_REPLY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                   48'h0, 1'b1, 1'b0}},
        // reply from a new sender: learn only
        '{'{KIND_PACKET, ARP_OP_REPLY, 48'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          TYPED, '{ACT_NONE, OUT_OP_NONE, 48'h0, 32'h0, 32'h0, 48'h0, 1'b1, 1'b0}},
        // known sender with a new MAC: table unchanged
        '{'{KIND_PACKET, ARP_OP_REPLY, 48'h0123_4567_89AB, 32'h0, 32'h0A00_0001, 32'h0},
          MODELLED, '0},
        // request for someone else is still answered
        '{'{KIND_PACKET, ARP_OP_REQUEST, 48'hA5A5_A5A5_A5A5, 32'hFFFF_FFFF, 32'hC0A8_0001,
            32'h0}, MODELLED, '0},
        '{'{KIND_LOOKUP, ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF},
          MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h0}, MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h1}, MODELLED, '0},
        '{'{KIND_PACKET, ARP_OP_REQUEST, 48'h5555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h5555_5555}, MODELLED, '0},
        '{'{KIND_PACKET, ARP_OP_REPLY, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hAAAA_AAAA}, MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h5555_5555}, MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'hAAAA_AAAA}, MODELLED, '0},
        // lookups never learn, whatever the packet fields hold
        '{'{KIND_LOOKUP, ARP_OP_REPLY, 48'h1234_5678_9ABC, 32'h1234_5678, 32'h0,
            32'h1234_5678}, MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h1234_5678}, MODELLED, '0},
        '{'{KIND_PACKET, ARP_OP_REPLY, 48'h8000_0000_0000, 32'h8000_0000, 32'h0, 32'h0},
          MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h8000_0000}, MODELLED, '0},
        '{'{KIND_PACKET, 16'h0003, 48'h0BAD_0BAD, 32'h0BAD_0BAD, 32'h0, 32'h0},
          MODELLED, '0},
        '{'{KIND_LOOKUP, 16'h0, 48'h0, 32'h0, 32'h0, 32'h0BAD_0BAD}, MODELLED, '0}
    };

    arp_responder_cache_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .opcode     (opcode),
        .sender_mac (sender_mac),
        .sender_ip  (sender_ip),
        .target_ip  (target_ip),
        .query_ip   (query_ip),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .action     (action),
        .out_opcode (out_opcode),
        .dest_mac   (dest_mac),
        .dest_ip    (dest_ip),
        .source_ip  (source_ip),
        .found_mac  (found_mac),
        .learned    (learned),
        .table_full (table_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Return the slot holding ip, or -1 when absent
    function automatic int find_slot(logic [31:0] ip);
        for (int i = 0; i < known_count; i++)
            if (known_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // Work out the result of one request and update the local table
    function automatic arp_result_t arp_outcome(arp_item_t it);
        arp_result_t r;
        int slot;
        r = '0;
        if (it.kind == KIND_LOOKUP)
        begin
            slot = find_slot(it.qip);
            if (slot >= 0)
            begin
                r.action    = ACT_HIT;
                r.found_mac = known_mac[slot];
            end
            else
            begin
                r.action     = ACT_BCAST;
                r.out_opcode = OUT_OP_REQUEST;
                r.dest_ip    = it.qip;
                r.source_ip  = station_ip;
            end
        end
        else if (it.opcode == ARP_OP_REQUEST || it.opcode == ARP_OP_REPLY)
        begin
            if (it.opcode == ARP_OP_REQUEST)
            begin
                r.action     = ACT_REPLY;
                r.out_opcode = OUT_OP_REPLY;
                r.dest_mac   = it.smac;
                r.dest_ip    = it.sip;
                r.source_ip  = it.tip;
            end
            // learn the sender unless already known or out of room
            if (find_slot(it.sip) < 0)
            begin
                if (known_count >= TABLE_DEPTH)
                    r.table_full = 1'b1;
                else
                begin
                    known_ip[known_count]  = it.sip;
                    known_mac[known_count] = it.smac;
                    known_count++;
                    r.learned = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_result(string why, arp_result_t want, arp_result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("result mismatch (%s) at %0t", why, $realtime);
            $display("  exp act=%0d op=%0d dmac=%h dip=%h sip=%h fmac=%h lrn=%b full=%b",
                     want.action, want.out_opcode, want.dest_mac, want.dest_ip,
                     want.source_ip, want.found_mac, want.learned, want.table_full);
            $display("  got act=%0d op=%0d dmac=%h dip=%h sip=%h fmac=%h lrn=%b full=%b",
                     got.action, got.out_opcode, got.dest_mac, got.dest_ip,
                     got.source_ip, got.found_mac, got.learned, got.table_full);
        end
    endtask

    // Check delivered results, predict accepted requests, track register writes
    always @(posedge clk)
    begin : check_and_predict
        arp_result_t got;
        arp_result_t due;
        arp_item_t   seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.action     = action_t'(action);
                got.out_opcode = out_opcode;
                got.dest_mac   = dest_mac;
                got.dest_ip    = dest_ip;
                got.source_ip  = source_ip;
                got.found_mac  = found_mac;
                got.learned    = learned;
                got.table_full = table_full;
                if (pending_outcomes.size() == 0)
                    flag_result("no request outstanding", '0, got);
                else
                begin
                    due = pending_outcomes.pop_front();
                    if (got !== due)
                        flag_result("wrong field", due, got);
                end
            end
            if (in_valid && !in_stall)
            begin
                seen = '{kind, opcode, sender_mac, sender_ip, target_ip, query_ip};
                due  = arp_outcome(seen);
                pending_outcomes.push_back(pin_on ? pin_want : due);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_OWN_IP)
                    station_ip = cfg_data[31:0];
                else
                    station_mac = cfg_data;
            end
        end
    end

    // Result side: long hold-offs on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_stall   <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left   <= LONG_HOLD;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_request(arp_item_t it, logic pinned, arp_result_t want);
        // idle the sender at random before offering
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid   <= 1'b1;
        kind       <= it.kind;
        opcode     <= it.opcode;
        sender_mac <= it.smac;
        sender_ip  <= it.sip;
        target_ip  <= it.tip;
        query_ip   <= it.qip;
        pin_on     <= pinned;
        pin_want   <= want;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic set_station(logic [47:0] mac, logic [31:0] ip);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_MAC;
        cfg_data  <= mac;
        @(posedge clk);
        cfg_index <= CFG_OWN_IP;
        cfg_data  <= {16'h0, ip};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] random_mac();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[47:0];
    endfunction

    // Mostly well-formed packets and lookups drawn from an address pool
    function automatic arp_item_t random_item(int pool_used, int fresh_pct);
        arp_item_t it;
        int pick;
        it.smac = random_mac();
        it.kind = ($urandom_range(99) < 40) ? KIND_LOOKUP : KIND_PACKET;
        pick = $urandom_range(99);
        if (pick < 45)
            it.opcode = ARP_OP_REQUEST;
        else if (pick < 90)
            it.opcode = ARP_OP_REPLY;
        else
            it.opcode = 16'($urandom);
        it.sip = ($urandom_range(99) < fresh_pct) ? 32'($urandom)
                                                  : ip_pool[$urandom_range(pool_used - 1)];
        it.tip = ($urandom_range(99) < 50) ? 32'($urandom)
                                           : ip_pool[$urandom_range(POOL_SIZE - 1)];
        it.qip = ($urandom_range(99) < 25) ? 32'($urandom)
                                           : ip_pool[$urandom_range(pool_used - 1)];
        return it;
    endfunction

    task automatic stream_requests(int goal, int pool_used, int fresh_pct, int hold_at,
                                   int pause_at);
        arp_item_t it;
        int sent;
        sent = 0;
        while (sent < goal)
        begin
            it = random_item(pool_used, fresh_pct);
            push_request(it, MODELLED, '0);
            sent++;
            // starve the result side while requests keep coming
            if (sent == hold_at)
                hold_requests <= hold_requests + 1;
            // hold back until every outstanding result is in
            if (sent == pause_at)
                settle();
        end
    endtask

    initial
    begin : stimulus
        for (int k = 0; k < POOL_SIZE; k++)
            ip_pool[k] = $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows against all-ones station registers
        set_station(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        foreach (directed_rows[r])
            push_request(directed_rows[r].stim, directed_rows[r].pinned,
                         directed_rows[r].want);
        settle();

        // Small pool: table stays partly filled
        set_station('0, '0);
        stream_requests(650, 10, 0, 200, -1);
        settle();

        // Full pool with fresh senders: table fills up
        sender_idle_pct = 55;
        rx_idle_pct <= 15;
        set_station(random_mac(), $urandom);
        stream_requests(650, POOL_SIZE, 15, -1, 300);
        settle();

        // Back to back on both sides
        sender_idle_pct = 0;
        rx_idle_pct <= 0;
        set_station(random_mac(), $urandom);
        stream_requests(650, POOL_SIZE, 30, -1, -1);
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
